### design/gbfp_pkg.sv
// Shared types, constants and the fix-kind mapping for the binary frame parser.
// No dependencies; used by gbfp_parse, gbfp_out_buf and gnss_binary_frame_parser.
`default_nettype none

package gbfp_pkg;

    // Frame framing bytes
    localparam logic [7:0] SYNC_1 = 8'hB5;
    localparam logic [7:0] SYNC_2 = 8'h62;

    // Navigation solution frame identity
    localparam logic [7:0]  PVT_CLASS = 8'h01;
    localparam logic [7:0]  PVT_ID    = 8'h07;
    localparam logic [15:0] PVT_LEN   = 16'd92;

    // Payload offsets of the captured fields
    localparam logic [15:0] FIX_OFS   = 16'd20;
    localparam logic [15:0] SATS_OFS  = 16'd23;
    localparam logic [15:0] LON_OFS   = 16'd24;
    localparam logic [15:0] LAT_OFS   = 16'd28;
    localparam logic [15:0] HMSL_OFS  = 16'd36;
    localparam logic [15:0] HACC_OFS  = 16'd40;

    localparam int NUM_WORDS = 4;

    // Fix kinds reported on the result
    localparam logic [1:0] FIX_NO_RX  = 2'd0;
    localparam logic [1:0] FIX_NONE   = 2'd1;
    localparam logic [1:0] FIX_2D     = 2'd2;
    localparam logic [1:0] FIX_3D     = 2'd3;

    typedef struct packed {
        logic [7:0]         msg_class;
        logic [7:0]         msg_id;
        logic [9:0]         payload_len;
        logic               checksum_ok;
        logic               pvt_valid;
        logic signed [31:0] longitude;
        logic signed [30:0] latitude;
        logic signed [31:0] msl_height;
        logic [31:0]        horiz_accuracy;
        logic [1:0]         fix_kind;
        logic [7:0]         sat_count;
    } res_t;

    function automatic logic [1:0] map_fix(input logic [7:0] raw);
        logic [1:0] kind;
        case (raw) inside
            8'd0, 8'd1, 8'd5: kind = FIX_NONE;
            8'd2:             kind = FIX_2D;
            8'd3, 8'd4:       kind = FIX_3D;
            default:          kind = FIX_NO_RX;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

### design/gbfp_parse.sv
// Frame state machine, running Fletcher sum and payload field capture.
// Depends on gbfp_pkg; one byte is taken per step strobe.
`default_nettype none

module gbfp_parse #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     rx_byte,
    output logic                res_fire,
    output gbfp_pkg::res_t      res
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN1    = 4'd4;
    localparam logic [3:0] PH_LEN2    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK1     = 4'd7;
    localparam logic [3:0] PH_CK2     = 4'd8;

    localparam logic [15:0] WORD_OFS [gbfp_pkg::NUM_WORDS] = '{
        gbfp_pkg::LON_OFS, gbfp_pkg::LAT_OFS, gbfp_pkg::HMSL_OFS, gbfp_pkg::HACC_OFS
    };

    logic [3:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       ck_a_reg, ck_a_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      len_reg, len_next;
    logic [gbfp_pkg::NUM_WORDS-1:0][31:0] word_reg, word_next;
    logic [7:0]       fix_reg, fix_next;
    logic [7:0]       sats_reg, sats_next;

    logic [7:0]       a_add;
    logic [7:0]       b_add;
    logic [15:0]      len_full;
    logic [IDX_W-1:0] idx_inc;
    logic [15:0]      idx_wide;
    logic             ok;
    logic             pvt;

    assign a_add    = sum_a_reg + rx_byte;
    assign b_add    = sum_b_reg + a_add;
    assign len_full = {rx_byte, len_reg[7:0]};
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_wide = 16'(idx_reg);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next  = ck_a_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        word_next  = word_reg;
        fix_next   = fix_reg;
        sats_next  = sats_reg;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == gbfp_pkg::SYNC_1)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                phase_next = (rx_byte == gbfp_pkg::SYNC_2) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                // restart the sum: A = B = first covered byte
                sum_a_next = rx_byte;
                sum_b_next = rx_byte;
                class_next = rx_byte;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                sum_a_next = a_add;
                sum_b_next = b_add;
                id_next    = rx_byte;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                sum_a_next = a_add;
                sum_b_next = b_add;
                len_next   = {8'd0, rx_byte};
                phase_next = PH_LEN2;
            end
            PH_LEN2:
            begin
                sum_a_next = a_add;
                sum_b_next = b_add;
                len_next   = len_full;
                idx_next   = '0;
                // drop oversize frames without a result
                if (len_full > 16'(MAX_PAYLOAD))
                    phase_next = PH_SYNC1;
                else if (len_full == 16'd0)
                    phase_next = PH_CK1;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = a_add;
                sum_b_next = b_add;
                if (idx_wide == gbfp_pkg::FIX_OFS)
                    fix_next = rx_byte;
                if (idx_wide == gbfp_pkg::SATS_OFS)
                    sats_next = rx_byte;
                for (int k = 0; k < gbfp_pkg::NUM_WORDS; k++)
                begin
                    if ((idx_wide >> 2) == (WORD_OFS[k] >> 2))
                        word_next[k][8*idx_reg[1:0] +: 8] = rx_byte;
                end
                idx_next = idx_inc;
                if (16'(idx_inc) >= len_reg)
                    phase_next = PH_CK1;
            end
            PH_CK1:
            begin
                ck_a_next  = rx_byte;
                phase_next = PH_CK2;
            end
            PH_CK2:
            begin
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            idx_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            ck_a_reg  <= '0;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            word_reg  <= '0;
            fix_reg   <= '0;
            sats_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            ck_a_reg  <= ck_a_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
            fix_reg   <= fix_next;
            sats_reg  <= sats_next;
        end
    end

    assign ok  = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign pvt = ok && (class_reg == gbfp_pkg::PVT_CLASS) && (id_reg == gbfp_pkg::PVT_ID)
                 && (len_reg == gbfp_pkg::PVT_LEN);

    assign res_fire = (phase_reg == PH_CK2);

    always_comb
    begin
        res                = '0;
        res.msg_class      = class_reg;
        res.msg_id         = id_reg;
        res.payload_len    = len_reg[9:0];
        res.checksum_ok    = ok;
        res.pvt_valid      = pvt;
        if (pvt)
        begin
            res.longitude      = word_reg[0];
            res.latitude       = word_reg[1][30:0];
            res.msl_height     = word_reg[2];
            res.horiz_accuracy = word_reg[3];
            res.fix_kind       = gbfp_pkg::map_fix(fix_reg);
            res.sat_count      = sats_reg;
        end
    end

endmodule

`default_nettype wire

### design/gbfp_out_buf.sv
// Two-entry result buffer that decouples the parser from a stalling receiver.
// Depends on gbfp_pkg for the result type.
`default_nettype none

module gbfp_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  gbfp_pkg::res_t      push_data,
    output logic                space,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gbfp_pkg::res_t      out_data
);

    gbfp_pkg::res_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/gnss_binary_frame_parser.sv
// Binary GNSS frame parser: byte input register, parser and result buffer.
// Depends on gbfp_pkg, gbfp_parse and gbfp_out_buf.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   request. Output channel (out_valid/out_ready) gives one request per
//   completed frame: class, id, length, checksum status and, for a good
//   navigation solution frame, position, accuracy, fix kind and satellites.
//   Oversize frames and lost sync give no request.
// Timing:
//   One byte per cycle sustained while the result buffer has space. A byte
//   is held in the input register and parsed there; the frame result enters
//   the result buffer when the last checksum byte steps the parser, so
//   out_valid rises after that byte passes the input register and buffer.
// Reset:
//   Parser returns to hunting for the first sync byte; both buffers empty.
// Stall:
//   The two-entry result buffer absorbs a stalled receiver; once it is full
//   and a finished frame waits, the input register holds and in_ready drops.
`default_nettype none

module gnss_binary_frame_parser #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              msg_class,
    output logic [7:0]              msg_id,
    output logic [9:0]              payload_len,
    output logic                    checksum_ok,
    output logic                    pvt_valid,
    output logic signed [31:0]      longitude,
    output logic signed [30:0]      latitude,
    output logic signed [31:0]      msl_height,
    output logic [31:0]             horiz_accuracy,
    output logic [1:0]              fix_kind,
    output logic [7:0]              sat_count
);

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       res_fire;
    logic       space;
    logic       step;
    gbfp_pkg::res_t res;
    gbfp_pkg::res_t out_data;

    // advance the held byte unless it finishes a frame and the buffer is full
    assign step     = byte_valid_reg && (!res_fire || space);
    assign in_ready = !byte_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= rx_byte;
    end

    gbfp_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .rx_byte  (byte_reg),
        .res_fire (res_fire),
        .res      (res)
    );

    gbfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_fire),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign msg_class      = out_data.msg_class;
    assign msg_id         = out_data.msg_id;
    assign payload_len    = out_data.payload_len;
    assign checksum_ok    = out_data.checksum_ok;
    assign pvt_valid      = out_data.pvt_valid;
    assign longitude      = out_data.longitude;
    assign latitude       = out_data.latitude;
    assign msl_height     = out_data.msl_height;
    assign horiz_accuracy = out_data.horiz_accuracy;
    assign fix_kind       = out_data.fix_kind;
    assign sat_count      = out_data.sat_count;

endmodule

`default_nettype wire
